// ----- hdl/jife_pkg.sv -----
// Shared constants, types and codes of the JSON integer field extractor.
`default_nettype none
package jife_pkg;

    // Key storage and window geometry.
    localparam int KEY_MAX_BYTES = 16;
    localparam int KEY_LEN_W     = 5;
    localparam int KEY_IDX_W     = 4;
    localparam int WIN_CELLS     = KEY_MAX_BYTES + 1;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LEN  = 2'd2;

    // Character codes used by the parser.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // Parse phases.
    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_PRE_COLON,
        PH_POST_COLON,
        PH_AFTER_MINUS,
        PH_DIGITS,
        PH_DONE,
        PH_FAIL
    } phase_t;

    // What a window cell must hold for the needle to match.
    typedef enum logic [1:0] {
        ROLE_SKIP,
        ROLE_KEY,
        ROLE_QUOTE
    } cell_role_t;

    typedef struct packed {
        cell_role_t role;
        logic [7:0] want;
    } cell_ctl_t;

    // Shift and clear commands for the window chain.
    typedef struct packed {
        logic shift;
        logic clear;
    } chain_cmd_t;

    // One result item.
    typedef struct packed {
        logic               found;
        logic signed [31:0] value;
    } result_t;

endpackage
`default_nettype wire

// ----- hdl/jife_in_if.sv -----
// Input channel: one payload byte per item with an end-of-payload flag.
`default_nettype none
interface jife_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       final_byte;

    modport source (output valid, output payload_byte, output final_byte, input ready);
    modport sink (input valid, input payload_byte, input final_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/jife_out_if.sv -----
// Output channel: found flag and parsed signed value per item.
`default_nettype none
interface jife_out_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [31:0] value;

    modport source (output valid, output found, output value, input ready);
    modport sink (input valid, input found, input value, output ready);
endinterface
`default_nettype wire

// ----- hdl/jife_cell.sv -----
// One window cell: holds a recent byte with its valid bit and checks it against the needle.
`default_nettype none
module jife_cell
    import jife_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire chain_cmd_t cmd,
    input  wire logic [7:0] byte_in,
    input  wire logic       valid_in,
    input  wire cell_ctl_t  ctl,
    output logic [7:0]      byte_out,
    output logic            valid_out,
    output logic            ok
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       valid_reg;
    logic       valid_next;

    // Shift from the left neighbor; the end of a payload empties the window.
    always_comb
    begin
        byte_next  = byte_reg;
        valid_next = valid_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.shift)
        begin
            byte_next  = byte_in;
            valid_next = valid_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    // Compare the held byte with what the needle wants at this position.
    always_comb
    begin
        case (ctl.role)
            ROLE_KEY:   ok = (byte_reg == ctl.want);
            ROLE_QUOTE: ok = valid_reg && (byte_reg == CH_QUOTE);
            default:    ok = 1'b1;
        endcase
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule
`default_nettype wire

// ----- hdl/jife_parser.sv -----
// Parse sequencer after the key match: colon, sign and decimal digit accumulation.
`default_nettype none
module jife_parser
    import jife_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] char_in,
    input  wire logic       last_in,
    input  wire logic       needle_hit,
    output logic            searching,
    output result_t         result
);

    phase_t      phase_reg;
    phase_t      phase_next;
    phase_t      phase_step;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] acc_step;
    logic        minus_reg;
    logic        minus_next;
    logic        minus_step;
    logic        is_digit;
    logic        is_blank;
    logic        take_digit;
    logic [31:0] digit_val;

    assign is_digit  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    assign is_blank  = (char_in == CH_SPACE) || (char_in == CH_TAB);
    assign digit_val = {24'd0, char_in - CH_ZERO};

    // Next phase for the current byte, then the end of payload restarts the search.
    always_comb
    begin
        phase_step = phase_reg;
        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (needle_hit)
                begin
                    phase_step = PH_PRE_COLON;
                end
            end
            PH_PRE_COLON:
            begin
                if (char_in == CH_COLON)
                begin
                    phase_step = PH_POST_COLON;
                end
                else if (!is_blank)
                begin
                    phase_step = PH_FAIL;
                end
            end
            PH_POST_COLON:
            begin
                if (char_in == CH_MINUS)
                begin
                    phase_step = PH_AFTER_MINUS;
                end
                else if (is_digit)
                begin
                    phase_step = PH_DIGITS;
                end
                else if (!is_blank)
                begin
                    phase_step = PH_FAIL;
                end
            end
            PH_AFTER_MINUS:
            begin
                phase_step = is_digit ? PH_DIGITS : PH_FAIL;
            end
            PH_DIGITS:
            begin
                if (!is_digit)
                begin
                    phase_step = PH_DONE;
                end
            end
            default:
            begin
                phase_step = phase_reg;
            end
        endcase

        phase_next = phase_reg;
        if (step)
        begin
            phase_next = last_in ? PH_SEARCH : phase_step;
        end
    end

    // Digit accumulation, sign capture and the result for a final byte.
    always_comb
    begin
        case (phase_reg) inside
            PH_POST_COLON, PH_AFTER_MINUS, PH_DIGITS: take_digit = is_digit;
            default:                                  take_digit = 1'b0;
        endcase

        acc_step   = take_digit ? ((acc_reg << 3) + (acc_reg << 1) + digit_val) : acc_reg;
        minus_step = minus_reg || ((phase_reg == PH_POST_COLON) && (char_in == CH_MINUS));

        acc_next   = acc_reg;
        minus_next = minus_reg;
        if (step)
        begin
            acc_next   = last_in ? 32'd0 : acc_step;
            minus_next = last_in ? 1'b0 : minus_step;
        end

        result.found = (phase_step == PH_DIGITS) || (phase_step == PH_DONE);
        if (!result.found)
        begin
            result.value = '0;
        end
        else if (minus_step)
        begin
            result.value = -$signed(acc_step);
        end
        else
        begin
            result.value = $signed(acc_step);
        end

        searching = (phase_reg == PH_SEARCH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            minus_reg <= minus_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/json_integer_field_extractor.sv -----
// Top level of the JSON integer field extractor: key window chain, parser and result register.
//
// Usage: a payload enters on in_chan one byte per item, its last byte flagged by
// final_byte. The block finds the first quoted appearance of the configured key,
// then parses blanks, a colon, blanks, an optional minus sign and decimal digits.
// One result item leaves on out_chan for each payload, after its final byte:
// found and the 32-bit signed value (wrapping modulo 2^32, zero when not found).
// Bytes other than the final one produce no result.
// The key is set through cfg_we / cfg_index / cfg_data: index 0 holds key
// characters 0 to 7, index 1 characters 8 to 15, index 2 the key length.
// Throughput: one byte per cycle while in_chan is ready; while searching, the window of 17 cells
// shifts in every byte and compares it against the needle in the same cycle it arrives.
// Latency: the result is valid in the cycle after the final byte is accepted.
// Stall: a waiting result sits in the output register; in_chan stays ready while
// that register is empty or being drained, so a new payload can stream in behind
// it, and input stops only while a result waits untaken.
// Reset: rst_n clears the key registers, the window and the parse state, and
// drops out_chan.valid. After each payload the parse state restarts by itself.
`default_nettype none
module json_integer_field_extractor
    import jife_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    jife_in_if.sink                     in_chan,
    jife_out_if.source                  out_chan,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CFG_DATA_W-1:0] key_low_reg;
    logic [CFG_DATA_W-1:0] key_high_reg;
    logic [KEY_LEN_W-1:0]  key_len_reg;
    logic [KEY_LEN_W-1:0]  key_len_used;
    logic [2*CFG_DATA_W-1:0] key_all;

    logic       step;
    logic       searching;
    logic       needle_hit;
    chain_cmd_t cmd;
    result_t    result;

    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_data_reg;

    logic [7:0]        cell_byte  [WIN_CELLS];
    logic              cell_valid [WIN_CELLS];
    cell_ctl_t         cell_ctl   [WIN_CELLS];
    logic [WIN_CELLS-1:0] cell_ok;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LEN:  key_len_reg  <= cfg_data[KEY_LEN_W-1:0];
                default:      key_len_reg  <= key_len_reg;
            endcase
        end
    end

    // Lengths above the key capacity use the full key.
    assign key_len_used = (key_len_reg > KEY_LEN_W'(KEY_MAX_BYTES)) ?
                          KEY_LEN_W'(KEY_MAX_BYTES) : key_len_reg;
    assign key_all      = {key_high_reg, key_low_reg};

    // Handshake: accept while the result register is empty or draining.
    assign in_chan.ready = !out_valid_reg || out_chan.ready;
    assign step          = in_chan.valid && in_chan.ready;
    assign cmd.shift     = step && searching;
    assign cmd.clear     = step && in_chan.final_byte;

    // Window chain: cell i holds the byte that becomes needle position i+1.
    for (genvar i = 0; i < WIN_CELLS; i++)
    begin : g_cell
        logic [KEY_IDX_W-1:0] key_idx;
        logic [7:0]           prev_byte;
        logic                 prev_valid;

        assign key_idx = KEY_IDX_W'(key_len_used - KEY_LEN_W'(i) - KEY_LEN_W'(1));

        always_comb
        begin
            cell_ctl[i].want = key_all[{key_idx, 3'b000} +: 8];
            if (key_len_used == KEY_LEN_W'(i))
            begin
                cell_ctl[i].role = ROLE_QUOTE;
            end
            else if (KEY_LEN_W'(i) < key_len_used)
            begin
                cell_ctl[i].role = ROLE_KEY;
            end
            else
            begin
                cell_ctl[i].role = ROLE_SKIP;
            end
        end

        if (i == 0)
        begin : g_head
            assign prev_byte  = in_chan.payload_byte;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_byte  = cell_byte[i-1];
            assign prev_valid = cell_valid[i-1];
        end

        jife_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .byte_in   (prev_byte),
            .valid_in  (prev_valid),
            .ctl       (cell_ctl[i]),
            .byte_out  (cell_byte[i]),
            .valid_out (cell_valid[i]),
            .ok        (cell_ok[i])
        );
    end

    // The newest byte closes the needle with a quote.
    assign needle_hit = (in_chan.payload_byte == CH_QUOTE) && (&cell_ok);

    jife_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .char_in    (in_chan.payload_byte),
        .last_in    (in_chan.final_byte),
        .needle_hit (needle_hit),
        .searching  (searching),
        .result     (result)
    );

    // Result register between the parser and the receiver.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (step && in_chan.final_byte)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_chan.final_byte)
        begin
            out_data_reg <= result;
        end
    end

    assign out_chan.valid = out_valid_reg;
    assign out_chan.found = out_data_reg.found;
    assign out_chan.value = out_data_reg.value;

endmodule
`default_nettype wire
